// File: src/tfsou_pkg.sv
// ----------------------------------------------------------------------------
// tfsou_pkg: shared types and constants for the tab field splitter
// Byte codes, result kinds and the job record handed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package tfsou_pkg;

    // byte codes
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [7:0] BYTE_ZERO      = 8'h30;

    // result kinds
    localparam logic [1:0] KIND_FEATURE = 2'd0;
    localparam logic [1:0] KIND_CONTEXT = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // most results one input item can cause: three held escape bytes,
    // one byte (or a second held backslash) and the status
    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       ok;
    } result_t;

    // all results caused by one input item, in order
    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        result_t [MAX_RESULTS-1:0]    entries;
    } job_t;

endpackage

`default_nettype wire

// File: src/tab_field_split_octal_unescape.sv
// ----------------------------------------------------------------------------
// tab_field_split_octal_unescape: tab field splitter with octal unescape
// The first result of an item goes into the job queue, then the output
// register that drives m_tvalid. Throughput: one item per cycle while items
// give at most one result and m_tready does not stall; an item with n results
// (at most five) holds the result issue for all n of them, and the job queue
// (QueueDepth jobs) lets the parser run ahead meanwhile.
// Reset: asynchronous, clears parser state, queue and output valid at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tab_field_split_octal_unescape
#(
    parameter int QueueDepth = tfsou_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] line_byte
    input  wire logic        s_tlast,   // end_of_line
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_byte
    output logic [7:0]       m_tuser,   // [1:0] kind, [2] line_ok, rest zero
    output logic             m_tlast    // run_last
);

    logic             queue_full;
    logic             push;
    tfsou_pkg::job_t  push_job;
    logic             pop;
    logic             head_valid;
    tfsou_pkg::job_t  head_job;

    // parser
    tfsou_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // job queue
    tfsou_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // result issue
    tfsou_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// File: src/tfsou_front.sv
// ----------------------------------------------------------------------------
// tfsou_front: line parser
// Accepts one line byte per item, tracks the tab phase and escape state and
// turns each item into a job that lists all of its results.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsou_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] line_byte
    input  wire logic               s_tlast,   // end_of_line
    input  wire logic               queue_full,
    output logic                    push,
    output tfsou_pkg::job_t         push_job
);

    // phase codes
    localparam logic [1:0] PH_SKIP    = 2'd0;
    localparam logic [1:0] PH_FEATURE = 2'd1;
    localparam logic [1:0] PH_CONTEXT = 2'd2;

    // escape codes: nothing, backslash, backslash + one digit, + two digits
    localparam logic [1:0] ES_NONE  = 2'd0;
    localparam logic [1:0] ES_SLASH = 2'd1;
    localparam logic [1:0] ES_ONE   = 2'd2;
    localparam logic [1:0] ES_TWO   = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [1:0] es_reg, es_next;
    logic [2:0] d1_reg, d1_next;
    logic [2:0] d2_reg, d2_next;

    logic       accept;
    logic       is_digit;
    logic [2:0] digit;
    tfsou_pkg::job_t job;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign is_digit = (s_tdata[7:3] == tfsou_pkg::BYTE_ZERO[7:3]);
    assign digit    = s_tdata[2:0];

    // classify the item and list its results
    always_comb
    begin
        logic [tfsou_pkg::RES_CNT_W-1:0] n;
        n          = '0;
        job        = '0;
        phase_next = phase_reg;
        es_next    = es_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;

        unique case (phase_reg)
            PH_SKIP:
            begin
                if (s_tdata == tfsou_pkg::BYTE_TAB)
                begin
                    phase_next = PH_FEATURE;
                end
            end
            PH_FEATURE:
            begin
                if (s_tdata == tfsou_pkg::BYTE_TAB)
                begin
                    phase_next = PH_CONTEXT;
                end
                else
                begin
                    job.entries[n] = '{data: s_tdata, kind: tfsou_pkg::KIND_FEATURE,
                                       ok: 1'b0};
                    n = n + 1'b1;
                end
            end
            default:
            begin
                if (es_reg != ES_NONE && is_digit)
                begin
                    // escape continues
                    if (es_reg == ES_SLASH)
                    begin
                        d1_next = digit;
                        es_next = ES_ONE;
                    end
                    else if (es_reg == ES_ONE)
                    begin
                        d2_next = digit;
                        es_next = ES_TWO;
                    end
                    else
                    begin
                        job.entries[n] = '{data: {d1_reg[1:0], d2_reg, digit},
                                           kind: tfsou_pkg::KIND_CONTEXT, ok: 1'b0};
                        n = n + 1'b1;
                        es_next = ES_NONE;
                    end
                end
                else
                begin
                    // broken escape: held bytes go out unchanged
                    if (es_reg != ES_NONE)
                    begin
                        job.entries[n] = '{data: tfsou_pkg::BYTE_BACKSLASH,
                                           kind: tfsou_pkg::KIND_CONTEXT, ok: 1'b0};
                        n = n + 1'b1;
                    end
                    if (es_reg == ES_ONE || es_reg == ES_TWO)
                    begin
                        job.entries[n] = '{data: {tfsou_pkg::BYTE_ZERO[7:3], d1_reg},
                                           kind: tfsou_pkg::KIND_CONTEXT, ok: 1'b0};
                        n = n + 1'b1;
                    end
                    if (es_reg == ES_TWO)
                    begin
                        job.entries[n] = '{data: {tfsou_pkg::BYTE_ZERO[7:3], d2_reg},
                                           kind: tfsou_pkg::KIND_CONTEXT, ok: 1'b0};
                        n = n + 1'b1;
                    end
                    es_next = ES_NONE;
                    if (s_tdata == tfsou_pkg::BYTE_BACKSLASH)
                    begin
                        es_next = ES_SLASH;
                    end
                    else
                    begin
                        job.entries[n] = '{data: s_tdata, kind: tfsou_pkg::KIND_CONTEXT,
                                           ok: 1'b0};
                        n = n + 1'b1;
                    end
                end
            end
        endcase

        // end of line: flush what is held, then the status
        if (s_tlast)
        begin
            if (es_next != ES_NONE)
            begin
                job.entries[n] = '{data: tfsou_pkg::BYTE_BACKSLASH,
                                   kind: tfsou_pkg::KIND_CONTEXT, ok: 1'b0};
                n = n + 1'b1;
            end
            if (es_next == ES_ONE || es_next == ES_TWO)
            begin
                job.entries[n] = '{data: {tfsou_pkg::BYTE_ZERO[7:3], d1_next},
                                   kind: tfsou_pkg::KIND_CONTEXT, ok: 1'b0};
                n = n + 1'b1;
            end
            if (es_next == ES_TWO)
            begin
                job.entries[n] = '{data: {tfsou_pkg::BYTE_ZERO[7:3], d2_next},
                                   kind: tfsou_pkg::KIND_CONTEXT, ok: 1'b0};
                n = n + 1'b1;
            end
            // phase codes at or above the context code count as context
            job.entries[n] = '{data: 8'h00, kind: tfsou_pkg::KIND_STATUS,
                               ok: phase_next[1]};
            n = n + 1'b1;
            phase_next = PH_SKIP;
            es_next    = ES_NONE;
            d1_next    = '0;
            d2_next    = '0;
        end

        job.count = n;
    end

    assign push     = accept && (job.count != '0);
    assign push_job = job;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            es_reg    <= ES_NONE;
            d1_reg    <= '0;
            d2_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            es_reg    <= es_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
        end
    end

`ifndef SYNTHESIS
    // a line end leaves the parser at the start of a line
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (phase_reg == PH_SKIP && es_reg == ES_NONE))
        else $error("parser state not cleared after line end");

    // a line end always yields a job ending in a status result
    a_eol_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |-> (push && job.count <= tfsou_pkg::RES_CNT_W'(
            tfsou_pkg::MAX_RESULTS)))
        else $error("line end without a well-formed status job");
`endif

endmodule

`default_nettype wire

// File: src/tfsou_queue.sv
// ----------------------------------------------------------------------------
// tfsou_queue: job queue
// Small first-in first-out store of jobs between parser and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsou_queue
#(
    parameter int Depth = tfsou_pkg::QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tfsou_pkg::job_t    push_job,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output tfsou_pkg::job_t         head_job
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    tfsou_pkg::job_t mem_reg [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CntW'(1);
            2'b01:   count_next = count_reg - CntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    // the parser never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed while queue full");
`endif

endmodule

`default_nettype wire

// File: src/tfsou_back.sv
// ----------------------------------------------------------------------------
// tfsou_back: result issue
// Walks the head job into the output register one result per cycle when unstalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsou_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire tfsou_pkg::job_t    head_job,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // [7:0] data_byte
    output logic [7:0]              m_tuser,   // [1:0] kind, [2] line_ok, rest zero
    output logic                    m_tlast    // run_last
);

    logic [tfsou_pkg::RES_CNT_W-1:0] idx_reg, idx_next;
    logic                            valid_reg, valid_next;
    logic [7:0]                      data_reg;
    logic [1:0]                      kind_reg;
    logic                            ok_reg;
    logic                            last_reg;

    logic                 issue;
    logic                 is_last;
    tfsou_pkg::result_t   cur;

    // issue when the output register is free or being emptied
    assign issue   = head_valid && (!valid_reg || m_tready);
    assign cur     = head_job.entries[idx_reg];
    assign is_last = (idx_reg == head_job.count - 1'b1);
    assign pop     = issue && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        end
        if (issue)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            data_reg <= cur.data;
            kind_reg <= cur.kind;
            ok_reg   <= cur.ok;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = {5'b00000, ok_reg, kind_reg};
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    // the walk index stays inside the head job
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head_job.count))
        else $error("result index beyond job length");

    // a partly issued job is still at the head
    a_mid_job: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> head_valid)
        else $error("job left the queue before all results were issued");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for tab_field_split_octal_unescape
// Line bytes go in through the slave stream. A scoreboard class predicts the
// feature, context and line status results, and checks each received result
// in order. The directed lines come first, then random lines that are mostly
// well formed. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb;

    localparam int ITEM_TARGET    = 250;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 20;

    // parser position within the line
    typedef enum logic [1:0] {
        AT_PREAMBLE,
        AT_FEATURE,
        AT_CONTEXT
    } split_phase_t;

    // how much of an octal escape is being held
    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_SLASH,
        ESC_ONE_DIGIT,
        ESC_TWO_DIGITS
    } escape_stage_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       ok;
        logic       last;
    } split_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts results per line byte and checks them in order
    // ------------------------------------------------------------------------
    class line_split_board;
        split_result_t awaited[$];
        split_phase_t  phase;
        escape_stage_t esc_stage;
        logic [2:0]    digit_hi;
        logic [2:0]    digit_mid;
        int            errors;
        int            checked;
        int            lines_ok;
        int            lines_bad;
        int            escapes_decoded;

        function new();
            phase           = AT_PREAMBLE;
            esc_stage       = ESC_NONE;
            digit_hi        = '0;
            digit_mid       = '0;
            errors          = 0;
            checked         = 0;
            lines_ok        = 0;
            lines_bad       = 0;
            escapes_decoded = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void add_result(logic [7:0] data, logic [1:0] kind, logic ok);
            split_result_t r;
            r.data = data;
            r.kind = kind;
            r.ok   = ok;
            r.last = 1'b0;
            awaited.insert(awaited.size(), r);
        endfunction

        // held escape bytes come out unchanged
        function void flush_escape();
            if (esc_stage != ESC_NONE)
                add_result(tfsou_pkg::BYTE_BACKSLASH, tfsou_pkg::KIND_CONTEXT, 1'b0);
            if (esc_stage == ESC_ONE_DIGIT || esc_stage == ESC_TWO_DIGITS)
                add_result(tfsou_pkg::BYTE_ZERO + 8'(digit_hi), tfsou_pkg::KIND_CONTEXT,
                           1'b0);
            if (esc_stage == ESC_TWO_DIGITS)
                add_result(tfsou_pkg::BYTE_ZERO + 8'(digit_mid), tfsou_pkg::KIND_CONTEXT,
                           1'b0);
            esc_stage = ESC_NONE;
        endfunction

        function void unescape_context(logic [7:0] b);
            logic       is_octal;
            logic [2:0] d;
            is_octal = (b >= tfsou_pkg::BYTE_ZERO) && (b <= tfsou_pkg::BYTE_ZERO + 8'd7);
            d        = is_octal ? 3'(b - tfsou_pkg::BYTE_ZERO) : 3'd0;
            if (esc_stage != ESC_NONE && is_octal)
            begin
                case (esc_stage)
                    ESC_SLASH:
                    begin
                        digit_hi  = d;
                        esc_stage = ESC_ONE_DIGIT;
                    end
                    ESC_ONE_DIGIT:
                    begin
                        digit_mid = d;
                        esc_stage = ESC_TWO_DIGITS;
                    end
                    default:
                    begin
                        // 64*d1 mod 256 keeps only the two low bits of d1
                        add_result({digit_hi[1:0], digit_mid, d}, tfsou_pkg::KIND_CONTEXT,
                                   1'b0);
                        escapes_decoded++;
                        esc_stage = ESC_NONE;
                    end
                endcase
                return;
            end
            // broken escape: release held bytes, then handle b afresh
            flush_escape();
            if (b == tfsou_pkg::BYTE_BACKSLASH)
                esc_stage = ESC_SLASH;
            else
                add_result(b, tfsou_pkg::KIND_CONTEXT, 1'b0);
        endfunction

        // an accepted line byte; appends the results it causes
        function void note_byte(logic [7:0] b, logic eol);
            int   first_new;
            logic ok;
            first_new = awaited.size();
            case (phase)
                AT_PREAMBLE:
                begin
                    if (b == tfsou_pkg::BYTE_TAB)
                        phase = AT_FEATURE;
                end
                AT_FEATURE:
                begin
                    if (b == tfsou_pkg::BYTE_TAB)
                        phase = AT_CONTEXT;
                    else
                        add_result(b, tfsou_pkg::KIND_FEATURE, 1'b0);
                end
                default:
                begin
                    unescape_context(b);
                end
            endcase
            if (eol)
            begin
                ok = (phase != AT_PREAMBLE && phase != AT_FEATURE);
                flush_escape();
                add_result(8'h00, tfsou_pkg::KIND_STATUS, ok);
                phase     = AT_PREAMBLE;
                esc_stage = ESC_NONE;
                digit_hi  = '0;
                digit_mid = '0;
            end
            if (awaited.size() > first_new)
                awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [7:0] data, logic [7:0] user, logic last);
            split_result_t exp;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: data_byte %h tuser %h run_last %b",
                       data, user, last);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (exp.kind == tfsou_pkg::KIND_STATUS)
            begin
                if (exp.ok)
                    lines_ok++;
                else
                    lines_bad++;
            end
            if (data !== exp.data)
            begin
                $error("data_byte: expected %h, got %h", exp.data, data);
                errors++;
            end
            if (user[1:0] !== exp.kind)
            begin
                $error("kind: expected %0d, got %0d", exp.kind, user[1:0]);
                errors++;
            end
            if (user[2] !== exp.ok)
            begin
                $error("line_ok: expected %b, got %b", exp.ok, user[2]);
                errors++;
            end
            if (user[7:3] !== 5'd0)
            begin
                $error("tuser pad: expected 00, got %h", user[7:3]);
                errors++;
            end
            if (last !== exp.last)
            begin
                $error("run_last: expected %b, got %b", exp.last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [7:0] m_tuser;
    logic       m_tlast;

    line_split_board board;
    logic [7:0]      line_buf[$];
    int              sent_items  = 0;
    int              sent_lines  = 0;
    int              idle_cycles = 0;
    logic            tx_burst    = 1'b0;
    logic            rx_burst    = 1'b0;

    tab_field_split_octal_unescape u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eol);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        do @(posedge clk); while (!s_tready);
        board.note_byte(b, eol);
        sent_items++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        sent_lines++;
    endtask

    // append one byte to the line being built
    function automatic void append_byte(logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    function automatic logic [7:0] any_but_tab();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == tfsou_pkg::BYTE_TAB)
            b = 8'hFF;
        return b;
    endfunction

    function automatic logic [7:0] octal_char();
        return tfsou_pkg::BYTE_ZERO + 8'($urandom_range(0, 7));
    endfunction

    // mostly well-formed lines with escapes; some noise lines
    task automatic build_random_line();
        int n;
        int r;
        line_buf.delete();
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    append_byte(tfsou_pkg::BYTE_TAB);
                else if (r < 40)
                    append_byte(tfsou_pkg::BYTE_BACKSLASH);
                else if (r < 55)
                    append_byte(octal_char());
                else
                    append_byte(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            repeat ($urandom_range(0, 3)) append_byte(any_but_tab());
            append_byte(tfsou_pkg::BYTE_TAB);
            repeat ($urandom_range(0, 4)) append_byte(any_but_tab());
            append_byte(tfsou_pkg::BYTE_TAB);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    append_byte(tfsou_pkg::BYTE_BACKSLASH);
                    repeat (3) append_byte(octal_char());
                end
                else if (r < 45)
                begin
                    // escape cut short by a non-octal byte or by the line end
                    append_byte(tfsou_pkg::BYTE_BACKSLASH);
                    repeat ($urandom_range(0, 2)) append_byte(octal_char());
                    case ($urandom_range(0, 4))
                        0: append_byte(8'h38);   // '8'
                        1: append_byte(8'h2F);   // '/'
                        2: append_byte(tfsou_pkg::BYTE_BACKSLASH);
                        3: append_byte(tfsou_pkg::BYTE_TAB);
                        default: ;
                    endcase
                end
                else
                begin
                    append_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // receiver: random stalls per result, with stall-free stretches
    initial
    begin
        int gap;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(rst_n && m_tvalid));
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser, m_tlast);
    end

    // watchdog: too long with nothing accepted on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic paused;
        paused = 1'b0;
        board  = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dropped preamble, feature extremes, full and broken escapes,
        // later tab as context, five results from one byte
        line_buf = '{8'hFF, tfsou_pkg::BYTE_TAB, 8'h00, 8'hFF, tfsou_pkg::BYTE_TAB,
                     tfsou_pkg::BYTE_BACKSLASH, 8'h37, 8'h37, 8'h37,
                     tfsou_pkg::BYTE_BACKSLASH, tfsou_pkg::BYTE_BACKSLASH, 8'h32,
                     tfsou_pkg::BYTE_TAB,
                     tfsou_pkg::BYTE_BACKSLASH, 8'h31, 8'h32, 8'h71};
        send_line();
        // no tab at all
        line_buf = '{8'h41, 8'h42};
        send_line();
        // only one tab: feature bytes stay, line not ok
        line_buf = '{tfsou_pkg::BYTE_TAB, 8'h43, 8'h44};
        send_line();
        // empty feature, zero escape, backslash held at line end
        line_buf = '{tfsou_pkg::BYTE_TAB, tfsou_pkg::BYTE_TAB, tfsou_pkg::BYTE_BACKSLASH,
                     8'h30, 8'h30, 8'h30, tfsou_pkg::BYTE_BACKSLASH};
        send_line();

        while (sent_items < ITEM_TARGET)
        begin
            tx_burst = ($urandom_range(0, 4) == 0);
            build_random_line();
            send_line();
            // hold off once until everything has drained
            if (!paused && sent_items >= ITEM_TARGET / 2)
            begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                while (board.outstanding() > 0) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        while (board.outstanding() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d line bytes in %0d lines; checked %0d results.",
                 sent_items, sent_lines, board.checked);
        $display("Lines with both tabs: %0d, without: %0d; escapes decoded: %0d.",
                 board.lines_ok, board.lines_bad, board.escapes_decoded);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: tab_field_split_octal_unescape.f
src/tfsou_pkg.sv
src/tfsou_front.sv
src/tfsou_queue.sv
src/tfsou_back.sv
src/tab_field_split_octal_unescape.sv
tb/tb.sv
